FILE: sv/gamd_pkg.sv
// shared types, constants and power table function for the gyro air mouse delta block
`default_nettype none

package gamd_pkg;

  // fixed point setup of the gyro rates and the power table size
  localparam int unsigned FRAC_BITS       = 12;
  localparam int unsigned POW_TABLE_DEPTH = 64;

  // table depth is a power of two, so the table scalings are shifts
  localparam int unsigned POW_DEPTH_LOG2 = $clog2(POW_TABLE_DEPTH);
  localparam int unsigned ROOT_FRAC      = 9;

  // field and register widths
  localparam int unsigned RATE_W     = 16;
  localparam int unsigned DELTA_W    = 8;
  localparam int unsigned SENS_W     = 16;
  localparam int unsigned SF_W       = 9;
  localparam int unsigned DZ_W       = 15;
  localparam int unsigned THR_W      = 15;
  localparam int unsigned AMUL_W     = 12;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // smoothing weight is q1.8
  localparam int unsigned SF_FRAC = 8;
  localparam logic [SF_W-1:0] SF_ONE = SF_W'(256);
  localparam int unsigned ACC_W = RATE_W + SF_W + 1;

  // magnitude, excess and table indexing
  localparam int unsigned MAG_W       = RATE_W;
  localparam int unsigned EXCESS_SPAN = 32768;
  localparam int unsigned REM_W       = 15;
  localparam int unsigned SEG_W       = $clog2(POW_TABLE_DEPTH + 1);
  localparam int unsigned P_W         = MAG_W + SEG_W;
  // largest entry is 64 * fifth root of 2^(60-FRAC_BITS), below 2^17 for a fraction width above 5
  localparam int unsigned POW_W       = 17;

  // accelerated value and gain stage
  localparam int unsigned AMUL_FRAC  = 8;
  localparam int unsigned AV_W       = POW_W + AMUL_W - AMUL_FRAC + 1;
  localparam int unsigned V_W        = AV_W + 1;
  localparam int unsigned GAIN_SHIFT = FRAC_BITS + 8;

  // shared multiplier operands
  localparam int unsigned OPA_W  = 24;
  localparam int unsigned OPB_W  = 18;
  localparam int unsigned PROD_W = OPA_W + OPB_W;
  localparam logic [PROD_W-1:0] GAIN_BIAS = PROD_W'((64'd1 << GAIN_SHIFT) - 64'd1);

  // output saturation limits
  localparam logic signed [DELTA_W-1:0] DELTA_MAX = 8'sd127;
  localparam logic signed [DELTA_W-1:0] DELTA_MIN = -8'sd128;

  // register reset values
  localparam logic [SENS_W-1:0] SENS_RESET = SENS_W'(256);
  localparam logic [SF_W-1:0]   SF_RESET   = SF_W'(205);
  localparam logic [DZ_W-1:0]   DZ_RESET   = DZ_W'(205);
  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(1229);
  localparam logic [AMUL_W-1:0] AMUL_RESET = AMUL_W'(384);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SENSITIVITY,
    CFG_SMOOTHING,
    CFG_DEAD_ZONE,
    CFG_ACCEL_THR,
    CFG_ACCEL_MULT
  } cfg_reg_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC0,
    ST_MAC1,
    ST_RANGE,
    ST_INTERP,
    ST_SCALE,
    ST_GAIN,
    ST_DONE
  } state_e;

  // payloads
  typedef struct packed {
    logic                     kind;
    logic signed [RATE_W-1:0] rate_x;
    logic signed [RATE_W-1:0] rate_z;
  } in_item_t;

  typedef struct packed {
    logic signed [DELTA_W-1:0] delta_x;
    logic signed [DELTA_W-1:0] delta_y;
  } out_item_t;

  // one entry of the x^1.2 table, evaluated at elaboration
  function automatic logic [POW_W-1:0] pow_entry(input int unsigned idx);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] c;
    logic [63:0] t;
    n = (64'(idx) << (60 - FRAC_BITS)) >> POW_DEPTH_LOG2;
    r = '0;
    for (int b = 11; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c * c * c * c <= n) begin
        r = c;
      end
    end
    t = (64'(idx) * 64'(EXCESS_SPAN) * r) >> (POW_DEPTH_LOG2 + ROOT_FRAC);
    return t[POW_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: sv/gyro_air_mouse_delta.sv
// Gyro air mouse delta: a new sample is taken only after the previous result has
// moved to the output register. One shared 24x18 multiplier runs five steps per
// axis (two smoothing MACs, interpolation, accel scale, gain), X then Z, under a
// small sequencer. A clear item only zeroes both smoothing values, in idle.
// Reset (async, active low) loads register defaults, zeroes both smoothing values
// and empties the output register; no clearing pass is needed.
`default_nettype none

module gyro_air_mouse_delta import gamd_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire in_item_t              in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_item_t                  out_data_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  state_e state_q, state_d;
  logic   axis_q;

  logic [SENS_W-1:0] sens_q;
  logic [SF_W-1:0]   sf_q;
  logic [DZ_W-1:0]   dz_q;
  logic [THR_W-1:0]  thr_q;
  logic [AMUL_W-1:0] amul_q;

  logic signed [RATE_W-1:0] smx_q, smz_q;
  logic signed [RATE_W-1:0] rate_x_q, rate_z_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [RATE_W-1:0] s_q;
  logic                     neg_q;
  logic                     pow_on_q;
  logic [SEG_W-1:0]         seg_q;
  logic [REM_W-1:0]         rem_q;
  logic [POW_W-1:0]         y_q;
  logic signed [V_W-1:0]    v_q;
  logic signed [DELTA_W-1:0] dx_q, dy_q;
  logic                     out_valid_q;
  out_item_t                out_q;

  logic in_xfer, out_free, smp_start, clr_start;

  // transfer decode
  assign in_xfer   = in_valid_i && !in_stall_o;
  assign smp_start = in_xfer && !in_data_i.kind;
  assign clr_start = in_xfer && in_data_i.kind;
  assign out_free  = !out_valid_q || !out_stall_i;

  // power table, constant logic
  logic [POW_W-1:0] pow_tab [POW_TABLE_DEPTH+1];
  for (genvar gi = 0; gi <= POW_TABLE_DEPTH; gi++) begin : g_pow
    assign pow_tab[gi] = pow_entry(gi);
  end

  // shared multiplier
  logic signed [OPA_W-1:0]  op_a;
  logic signed [OPB_W-1:0]  op_b;
  logic signed [PROD_W-1:0] prod;
  assign prod = op_a * op_b;

  // smoothing weights and per axis selects
  logic [SF_W-1:0]          f_sat, f_inv;
  logic signed [RATE_W-1:0] rate_sel, prev_sel;
  assign f_sat    = (sf_q > SF_ONE) ? SF_ONE : sf_q;
  assign f_inv    = SF_ONE - f_sat;
  assign rate_sel = axis_q ? rate_z_q : rate_x_q;
  assign prev_sel = axis_q ? smz_q : smx_q;

  // smoothing sum, floor by arithmetic shift
  logic signed [ACC_W-1:0]  mac_sum;
  logic signed [RATE_W-1:0] s_new;
  assign mac_sum = acc_q + $signed(prod[ACC_W-1:0]);
  assign s_new   = mac_sum[SF_FRAC +: RATE_W];

  // dead zone and threshold
  logic [MAG_W-1:0] mag, mag_dz, excess;
  logic             in_dz, pow_on;
  logic [P_W-1:0]   p_pos;
  assign mag    = s_q[RATE_W-1] ? MAG_W'(-s_q) : MAG_W'(s_q);
  assign in_dz  = mag < MAG_W'(dz_q);
  assign mag_dz = in_dz ? '0 : mag;
  assign pow_on = mag_dz >= MAG_W'(thr_q);
  assign excess = mag_dz - MAG_W'(thr_q);
  assign p_pos  = P_W'(excess) * P_W'(POW_TABLE_DEPTH);

  // table interpolation
  logic [SEG_W-1:0] hi_idx;
  logic [POW_W-1:0] pow_lo, pow_hi, pow_diff;
  assign hi_idx   = (seg_q == SEG_W'(POW_TABLE_DEPTH)) ? seg_q : seg_q + SEG_W'(1);
  assign pow_lo   = pow_tab[seg_q];
  assign pow_hi   = pow_tab[hi_idx];
  assign pow_diff = (pow_hi > pow_lo) ? pow_hi - pow_lo : '0;

  // accelerated magnitude
  logic [AV_W-1:0]       accv;
  logic signed [V_W-1:0] av_s;
  assign accv = AV_W'(thr_q) + AV_W'(prod[AMUL_FRAC +: (POW_W + AMUL_W - AMUL_FRAC)]);
  assign av_s = V_W'(accv);

  // gain, negate, truncate toward zero, saturate
  logic [PROD_W-1:0]         gain_bias;
  logic signed [PROD_W-1:0]  gain_b, gain_t, neg_t;
  logic signed [DELTA_W-1:0] d_sat;
  assign gain_bias = prod[PROD_W-1] ? GAIN_BIAS : '0;
  assign gain_b    = prod + $signed(gain_bias);
  assign gain_t    = gain_b >>> GAIN_SHIFT;
  assign neg_t     = -gain_t;

  always_comb begin
    if (neg_t > DELTA_MAX) begin
      d_sat = DELTA_MAX;
    end else if (neg_t < DELTA_MIN) begin
      d_sat = DELTA_MIN;
    end else begin
      d_sat = neg_t[DELTA_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (smp_start) state_d = ST_MAC0;
      ST_MAC0:   state_d = ST_MAC1;
      ST_MAC1:   state_d = ST_RANGE;
      ST_RANGE:  state_d = ST_INTERP;
      ST_INTERP: state_d = ST_SCALE;
      ST_SCALE:  state_d = ST_GAIN;
      ST_GAIN:   state_d = axis_q ? ST_DONE : ST_MAC0;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs: multiplier operands and handshakes
  always_comb begin
    op_a        = '0;
    op_b        = '0;
    in_stall_o  = (state_q != ST_IDLE);
    cfg_ready_o = (state_q == ST_IDLE);
    case (state_q)
      ST_MAC0: begin
        op_a = OPA_W'(rate_sel);
        op_b = OPB_W'(f_sat);
      end
      ST_MAC1: begin
        op_a = OPA_W'(prev_sel);
        op_b = OPB_W'(f_inv);
      end
      ST_INTERP: begin
        op_a = OPA_W'(pow_diff);
        op_b = OPB_W'(rem_q);
      end
      ST_SCALE: begin
        op_a = OPA_W'(y_q);
        op_b = OPB_W'(amul_q);
      end
      ST_GAIN: begin
        op_a = OPA_W'(v_q);
        op_b = OPB_W'(sens_q);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (smp_start) begin
        axis_q <= 1'b0;
      end else if (state_q == ST_GAIN) begin
        axis_q <= !axis_q;
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_q <= SENS_RESET;
      sf_q   <= SF_RESET;
      dz_q   <= DZ_RESET;
      thr_q  <= THR_RESET;
      amul_q <= AMUL_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_SENSITIVITY: sens_q <= cfg_data_i[SENS_W-1:0];
        CFG_SMOOTHING:   sf_q   <= cfg_data_i[SF_W-1:0];
        CFG_DEAD_ZONE:   dz_q   <= cfg_data_i[DZ_W-1:0];
        CFG_ACCEL_THR:   thr_q  <= cfg_data_i[THR_W-1:0];
        CFG_ACCEL_MULT:  amul_q <= cfg_data_i[AMUL_W-1:0];
        default: ;
      endcase
    end
  end

  // smoothing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smx_q <= '0;
      smz_q <= '0;
    end else if (clr_start) begin
      smx_q <= '0;
      smz_q <= '0;
    end else if (state_q == ST_MAC1) begin
      if (axis_q) begin
        smz_q <= s_new;
      end else begin
        smx_q <= s_new;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (smp_start) begin
      rate_x_q <= in_data_i.rate_x;
      rate_z_q <= in_data_i.rate_z;
    end
    case (state_q)
      ST_MAC0: acc_q <= $signed(prod[ACC_W-1:0]);
      ST_MAC1: s_q <= s_new;
      ST_RANGE: begin
        neg_q    <= s_q[RATE_W-1];
        pow_on_q <= pow_on;
        seg_q    <= p_pos[REM_W +: SEG_W];
        rem_q    <= p_pos[REM_W-1:0];
        v_q      <= in_dz ? '0 : V_W'(s_q);
      end
      ST_INTERP: y_q <= pow_lo + prod[REM_W +: POW_W];
      ST_SCALE: begin
        if (pow_on_q) begin
          v_q <= neg_q ? -av_s : av_s;
        end
      end
      ST_GAIN: begin
        if (axis_q) begin
          dx_q <= d_sat;
        end else begin
          dy_q <= d_sat;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_q.delta_x <= dx_q;
          out_q.delta_y <= dy_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: sv/gamd_chk.sv
// port level checker for the gyro air mouse delta block and its bind
`default_nettype none

module gamd_chk import gamd_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_stall_o,
  input wire in_item_t in_data_i,
  input wire logic     out_valid_o,
  input wire logic     out_stall_i,
  input wire out_item_t out_data_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result payload changed while stalled");

  // a sample transfer makes the block busy
  a_smp_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !in_data_i.kind |=> in_stall_o)
    else $error("block not busy after sample transfer");

  // a clear item finishes at once and frees the input
  a_clr_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.kind |=> !in_stall_o)
    else $error("block busy after clear item");

  // a new result only comes from a busy block
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without work in progress");

endmodule

bind gyro_air_mouse_delta gamd_chk u_gamd_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

FILE: tb/gyro_air_mouse_delta_tb.sv
// self-checking testbench for the gyro air mouse delta block: directed and random gyro traffic
module gyro_air_mouse_delta_tb import gamd_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint unsigned u64_t;

  // item kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  localparam logic signed [RATE_W-1:0] RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};
  localparam logic signed [RATE_W-1:0] RATE_MIN = {1'b1, {(RATE_W-1){1'b0}}};

  localparam int   UNITY_WEIGHT   = 1 << SF_FRAC;
  localparam u64_t ROOT_ONE       = 512;  // fifth root kept in q1.9
  localparam int   JITTER         = 300;
  localparam int   SETTLE_CYCLES  = 20;
  localparam int   HOLDOFF_CYCLES = 300;
  localparam int   PHASES         = 6;
  localparam int   PHASE_SAMPLES  = 65;
  localparam int   MAX_REPORTS    = 10;
  localparam int   TIMEOUT_NS     = 4_000_000;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  gyro_air_mouse_delta dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // mirror of the block: register copies, filter state, x^1.2 curve
  logic [SENS_W-1:0]        gain_cfg     = SENS_RESET;
  logic [SF_W-1:0]          weight_cfg   = SF_RESET;
  logic [DZ_W-1:0]          deadband_cfg = DZ_RESET;
  logic [THR_W-1:0]         knee_cfg     = THR_RESET;
  logic [AMUL_W-1:0]        boost_cfg    = AMUL_RESET;
  logic signed [RATE_W-1:0] filt_x       = '0;
  logic signed [RATE_W-1:0] filt_z       = '0;
  u64_t                     pow_curve [0:POW_TABLE_DEPTH];

  out_item_t pending_deltas[$];
  out_item_t want_delta;
  int        mismatch_count = 0;
  int        results_seen   = 0;

  // sender burst state
  int burst_left  = 0;
  bit steady_feed = 1'b0;

  // receiver stall pattern and hold-off request
  int stretch_left     = 0;
  int stall_pct        = 0;
  int holdoff_left     = 0;
  int holdoff_req_len  = 0;
  int holdoff_req_seq  = 0;
  int holdoff_seen_seq = 0;

  // interpolated x^1.2 of an excess in raw q units
  function automatic u64_t power_curve_at(u64_t excess);
    u64_t p;
    u64_t seg;
    u64_t rem;
    u64_t lo;
    u64_t hi;
    if (excess > EXCESS_SPAN) begin
      excess = EXCESS_SPAN;
    end
    p   = excess * POW_TABLE_DEPTH;
    seg = p / EXCESS_SPAN;
    rem = p % EXCESS_SPAN;
    lo  = pow_curve[seg];
    if (seg >= POW_TABLE_DEPTH) begin
      return lo;
    end
    hi = pow_curve[seg + 1];
    if (hi < lo) begin
      return lo;
    end
    return lo + ((hi - lo) * rem) / EXCESS_SPAN;
  endfunction

  // exponential filter, floor division by 256
  function automatic logic signed [RATE_W-1:0] filter_rate(logic signed [RATE_W-1:0] rate,
                                                          logic signed [RATE_W-1:0] prev);
    int weight;
    int acc;
    weight = (weight_cfg > SF_ONE) ? UNITY_WEIGHT : int'(weight_cfg);
    acc    = weight * int'(rate) + (UNITY_WEIGHT - weight) * int'(prev);
    return RATE_W'(acc >>> SF_FRAC);
  endfunction

  // dead zone, acceleration, negated gain and int8 saturation for one axis
  function automatic logic signed [DELTA_W-1:0] axis_delta(logic signed [RATE_W-1:0] s);
    longint v;
    longint mag;
    longint acc;
    longint d;
    u64_t   y;
    v   = s;
    mag = (v < 0) ? -v : v;
    if (mag < deadband_cfg) begin
      v   = 0;
      mag = 0;
    end
    if (mag >= knee_cfg) begin
      y   = power_curve_at(u64_t'(mag) - knee_cfg);
      acc = longint'(knee_cfg) + longint'((y * boost_cfg) >> AMUL_FRAC);
      v   = (v < 0) ? -acc : acc;
    end
    d = -(v * longint'(gain_cfg)) / (longint'(1) << GAIN_SHIFT);
    if (d > DELTA_MAX) begin
      d = DELTA_MAX;
    end
    if (d < DELTA_MIN) begin
      d = DELTA_MIN;
    end
    return DELTA_W'(d);
  endfunction

  // advance the mirror by one accepted item and queue its cursor delta
  function automatic void predict_cursor(in_item_t item);
    out_item_t res;
    if (item.kind == KIND_CLEAR) begin
      filt_x = '0;
      filt_z = '0;
      return;
    end
    filt_x      = filter_rate(item.rate_x, filt_x);
    filt_z      = filter_rate(item.rate_z, filt_z);
    res.delta_x = axis_delta(filt_z);
    res.delta_y = axis_delta(filt_x);
    pending_deltas.push_back(res);
  endfunction

  function automatic in_item_t gyro_sample(logic signed [RATE_W-1:0] x,
                                           logic signed [RATE_W-1:0] z);
    in_item_t item;
    item.kind   = KIND_SAMPLE;
    item.rate_x = x;
    item.rate_z = z;
    return item;
  endfunction

  // clear item, rate fields carry junk
  function automatic in_item_t clear_item();
    in_item_t item;
    item.kind   = KIND_CLEAR;
    item.rate_x = RATE_W'($urandom);
    item.rate_z = RATE_W'($urandom);
    return item;
  endfunction

  // rate mix: extremes, near the dead zone and knee, mid range, anything
  function automatic logic signed [RATE_W-1:0] pick_rate();
    int mag;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return RATE_MAX;
          1: return RATE_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
      1, 2, 3: mag = $urandom_range(0, 3000);
      4, 5: mag = $urandom_range(0, 12000);
      default: return RATE_W'($urandom);
    endcase
    return ($urandom_range(1) == 1) ? RATE_W'(-mag) : RATE_W'(mag);
  endfunction

  function automatic logic signed [RATE_W-1:0] jitter_rate(logic signed [RATE_W-1:0] target);
    int t;
    t = int'(target) + int'($urandom_range(0, 2 * JITTER)) - JITTER;
    if (t > int'(RATE_MAX)) begin
      t = int'(RATE_MAX);
    end
    if (t < int'(RATE_MIN)) begin
      t = int'(RATE_MIN);
    end
    return RATE_W'(t);
  endfunction

  // junk in the bits above a register's width
  function automatic logic [CFG_DATA_W-1:0] with_noise(int value, int width);
    return CFG_DATA_W'(($urandom << width) | value);
  endfunction

  // one item transfer, with bursty gaps unless a steady feed is asked for
  task automatic send_item(input in_item_t item);
    int gap;
    if (!steady_feed) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = ($urandom_range(1) == 0) ? 0 : $urandom_range(1, 20);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_cursor(item);
  endtask

  // register write transfer; the caller lowers valid after its last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (index)
      CFG_SENSITIVITY: gain_cfg     = data[SENS_W-1:0];
      CFG_SMOOTHING:   weight_cfg   = data[SF_W-1:0];
      CFG_DEAD_ZONE:   deadband_cfg = data[DZ_W-1:0];
      CFG_ACCEL_THR:   knee_cfg     = data[THR_W-1:0];
      CFG_ACCEL_MULT:  boost_cfg    = data[AMUL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input int sens, input int sf, input int dz, input int thr,
                           input int amul);
    write_reg(CFG_SENSITIVITY, CFG_DATA_W'(sens));
    write_reg(CFG_SMOOTHING, with_noise(sf, SF_W));
    write_reg(CFG_DEAD_ZONE, with_noise(dz, DZ_W));
    write_reg(CFG_ACCEL_THR, with_noise(thr, THR_W));
    write_reg(CFG_ACCEL_MULT, with_noise(amul, AMUL_W));
    cfg_valid_i <= 1'b0;
  endtask

  // stop feeding, wait for every pending delta and let a trailing clear finish
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (pending_deltas.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_default_config();
    send_item(gyro_sample('0, '0));
    send_item(gyro_sample(RATE_MAX, RATE_MAX));
    send_item(gyro_sample(RATE_MAX, RATE_MAX));
    send_item(gyro_sample(RATE_MIN, RATE_MIN));
    send_item(gyro_sample(RATE_MIN, RATE_MIN));
    send_item(gyro_sample(16'sd100, -16'sd100));
    send_item(clear_item());
    send_item(gyro_sample(RATE_MAX, RATE_MIN));
    send_item(gyro_sample(-16'sd1, 16'sd1));
  endtask

  task automatic test_register_extremes();
    // zero value at zero threshold, full gain and boost, new sample only
    wait_drain();
    write_all(65535, 256, 0, 0, 4095);
    send_item(gyro_sample('0, '0));
    send_item(gyro_sample(RATE_MAX, RATE_MIN));
    send_item(gyro_sample(RATE_MIN, RATE_MAX));
    send_item(gyro_sample(16'sd1, -16'sd1));
    // smoothing weight above one saturates, widest dead zone and knee, no gain
    wait_drain();
    write_all(0, 511, 32767, 32767, 0);
    send_item(gyro_sample(RATE_MAX, RATE_MIN));
    send_item(gyro_sample(RATE_MIN, RATE_MAX));
    // zero weight holds the filter, clear drops it
    wait_drain();
    write_all(256, 0, 205, 1229, 384);
    send_item(gyro_sample(RATE_MAX, RATE_MAX));
    send_item(clear_item());
    send_item(gyro_sample(RATE_MAX, RATE_MIN));
    // floor of smoothing on small negative sums
    wait_drain();
    write_all(4096, 1, 0, 32767, 384);
    send_item(gyro_sample(-16'sd1, -16'sd1));
    send_item(gyro_sample(-16'sd1, 16'sd1));
    send_item(gyro_sample(-16'sd300, 16'sd300));
    // indexes past the last register change nothing
    wait_drain();
    for (int idx = int'(CFG_ACCEL_MULT) + 1; idx < (1 << CFG_IDX_W); idx++) begin
      write_reg(CFG_IDX_W'(idx), CFG_DATA_W'($urandom));
    end
    cfg_valid_i <= 1'b0;
    send_item(gyro_sample(16'sd20000, -16'sd20000));
  endtask

  // receiver holds off while items keep coming, then the sender pauses to drain
  task automatic test_output_holdoff();
    wait_drain();
    steady_feed     = 1'b1;
    holdoff_req_len = HOLDOFF_CYCLES;
    holdoff_req_seq++;
    repeat (24) send_item(gyro_sample(pick_rate(), pick_rate()));
    steady_feed = 1'b0;
    wait_drain();
  endtask

  // gestures: runs of samples jittered around a target rate, some clears and noise items
  task automatic test_random_motion();
    int                       sent;
    int                       len;
    in_item_t                 item;
    logic signed [RATE_W-1:0] tx;
    logic signed [RATE_W-1:0] tz;
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drain();
      write_all(($urandom_range(2) == 0) ? $urandom_range(0, 65535) : $urandom_range(64, 1024),
                $urandom_range(0, 511),
                ($urandom_range(1) == 0) ? $urandom_range(0, 2000) : $urandom_range(0, 32767),
                ($urandom_range(2) != 0) ? $urandom_range(0, 6000) : $urandom_range(0, 32767),
                $urandom_range(0, 4095));
      sent = 0;
      while (sent < PHASE_SAMPLES) begin
        if ($urandom_range(9) == 0) begin
          item.kind   = ($urandom_range(1) == 1) ? KIND_CLEAR : KIND_SAMPLE;
          item.rate_x = RATE_W'($urandom);
          item.rate_z = RATE_W'($urandom);
          send_item(item);
          if (item.kind == KIND_SAMPLE) begin
            sent++;
          end
        end else begin
          len = $urandom_range(3, 20);
          tx  = pick_rate();
          tz  = pick_rate();
          for (int k = 0; k < len; k++) begin
            send_item(gyro_sample(jitter_rate(tx), jitter_rate(tz)));
          end
          sent += len;
          if ($urandom_range(4) == 0) begin
            send_item(clear_item());
          end
        end
      end
    end
  endtask

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("mismatch at result %0d: %s", results_seen, msg);
    end
  endtask

  // receiver stall pattern, stretches of varying stall density
  always @(posedge clk_i) begin
    if (holdoff_req_seq != holdoff_seen_seq) begin
      holdoff_seen_seq = holdoff_req_seq;
      holdoff_left     = holdoff_req_len;
    end
    if (stretch_left == 0) begin
      stretch_left = $urandom_range(10, 80);
      case ($urandom_range(3))
        0: stall_pct = 0;
        1: stall_pct = 25;
        2: stall_pct = 50;
        default: stall_pct = 85;
      endcase
    end
    stretch_left--;
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // result checker: each output transfer against the oldest pending delta
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_deltas.size() == 0) begin
        note_mismatch($sformatf("nothing pending, got delta_x %0d delta_y %0d",
                                out_data_o.delta_x, out_data_o.delta_y));
      end else begin
        want_delta = pending_deltas.pop_front();
        if (out_data_o.delta_x !== want_delta.delta_x) begin
          note_mismatch($sformatf("delta_x expected %0d got %0d",
                                  want_delta.delta_x, out_data_o.delta_x));
        end
        if (out_data_o.delta_y !== want_delta.delta_y) begin
          note_mismatch($sformatf("delta_y expected %0d got %0d",
                                  want_delta.delta_y, out_data_o.delta_y));
        end
      end
      results_seen++;
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

  initial begin
    u64_t root_in;
    u64_t root;
    u64_t c;
    // x^1.2 curve: entry i is e_i times the fifth root of e_i
    for (int i = 0; i <= POW_TABLE_DEPTH; i++) begin
      root_in = (u64_t'(i) << (60 - FRAC_BITS)) / POW_TABLE_DEPTH;
      root    = 0;
      c       = 1;
      while (c * c * c * c * c <= root_in) begin
        root = c;
        c++;
      end
      pow_curve[i] = (u64_t'(i) * EXCESS_SPAN * root) / (u64_t'(POW_TABLE_DEPTH) * ROOT_ONE);
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_config();
    test_register_extremes();
    test_output_holdoff();
    test_random_motion();
    wait_drain();

    if (mismatch_count == 0 && pending_deltas.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
